[rtl/rsqt_pkg.sv]
// Shared types, constants and command codes for the running residual quality tracker.
`timescale 1ns / 1ps
package rsqt_pkg;

  localparam int SAMPLE_BITS = 32;
  localparam int FRAC_BITS   = 8;
  localparam int COUNT_BITS  = 24;
  localparam int MEAN_BITS   = 48;
  localparam int MEAN_EXTRA  = MEAN_BITS - SAMPLE_BITS;
  localparam int SUM_BITS    = 64;
  localparam int MIN_BITS    = 16;
  localparam int LIM_BITS    = 31;
  localparam int STD_BITS    = 31;
  localparam int Q16_BITS    = 17;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 31;
  localparam int OUT_DATA_BITS = 128;
  localparam int STEP_BITS   = 6;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_SAMPLES = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STD_LIMIT   = 2'd1;

  localparam logic [MIN_BITS-1:0] MIN_SAMPLES_RST = 16'd10;
  localparam logic [LIM_BITS-1:0] STD_LIMIT_RST   = 31'd12800;

  localparam logic [STEP_BITS-1:0] DIV_LAST  = 6'd63;
  localparam logic [STEP_BITS-1:0] MUL_LAST  = 6'd47;
  localparam logic [STEP_BITS-1:0] SQRT_LAST = 6'd31;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_DELTA, OP_DIV_STEP, OP_MEAN, OP_DELTA2, OP_MUL_STEP,
    OP_ACC, OP_SQRT_INIT, OP_SQRT_STEP, OP_STD, OP_SCORE, OP_OUT
  } rsqt_op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DELTA, ST_DIV_MEAN, ST_MEAN, ST_DELTA2, ST_MUL, ST_ACC,
    ST_DIV_VAR, ST_SQRT_INIT, ST_SQRT, ST_STD, ST_DIV_FACT, ST_SCORE, ST_OUT
  } rsqt_state_t;

  typedef struct packed {
    rsqt_op_t op;
  } rsqt_cmd_t;

  typedef struct packed {
    logic count_gt1;
    logic out_busy;
  } rsqt_sts_t;

endpackage

[rtl/running_std_quality_tracker.sv]
// Top level of the running residual quality tracker: sequencer plus datapath.
`timescale 1ns / 1ps
// Usage:
//   in_*  : one signed Q.8 residual per request in in_tdata.
//   out_* : one result per input request, held in an output register until
//           out_tready takes it; a new input may be taken meanwhile.
//   cfg_* : write min_samples (index 0) or very_poor_std_limit (index 1);
//           write only while the block is idle.
// Sequence: when count > 1 a request runs through three 64-step divides,
// a 48-step multiply, a 32-step square root and the single-step states
// between them. While count <= 1 the variance divide and square root are
// skipped. The shared restoring divider takes most of the time; one
// request is in work at a time, in_tready is high only when the sequencer
// is idle.
// Reset (rst_n low, synchronous): count, mean and squared-deviation sum
// clear, registers take min_samples = 10 and limit = 12800, output empties.
// Stall: when out_tready is low the result holds; a finished request waits
// in its last step until the output register frees.
module running_std_quality_tracker
  import rsqt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [SAMPLE_BITS-1:0]   in_tdata,   // [31:0] sample
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // [23:0] seen_count, [55:24] mean_value, [86:56] std_dev,
  // [103:87] score_q16, [104] good_quality, [121:105] weight,
  // [122] pair_suitable, [127:123] zero
  output logic [OUT_DATA_BITS-1:0] out_tdata
);

  rsqt_cmd_t cmd;
  rsqt_sts_t sts;

  // Sequencer: walks each request through the shared units
  rsqt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: state, iterative arithmetic and the output register
  rsqt_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .sample     (in_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Standard deviation is zero while only one sample has been seen
  a_std_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[23:0] == 24'd1) |-> out_tdata[86:56] == '0)
    else $error("std nonzero for single sample");

  // Score never exceeds one
  a_score_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[103:87] <= 17'd65536)
    else $error("score above one");

  // Good flag matches the 0.7 threshold
  a_good: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[104] == (out_tdata[103:87] > 17'd45875))
    else $error("good flag mismatch");

  // No new input is taken while a request is in work
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted during work");

endmodule

[rtl/rsqt_ctrl.sv]
// Sequencer for the tracker: steps the shared datapath through one request.
`timescale 1ns / 1ps
module rsqt_ctrl
  import rsqt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  rsqt_sts_t sts,
  output rsqt_cmd_t cmd
);

  rsqt_state_t           state_r, state_nxt;
  logic [STEP_BITS-1:0]  step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = '0;
    cmd.op    = OP_NONE;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_DELTA;
        end
      end
      ST_DELTA: begin
        cmd.op    = OP_DELTA;
        state_nxt = ST_DIV_MEAN;
      end
      ST_DIV_MEAN: begin
        cmd.op   = OP_DIV_STEP;
        step_nxt = step_r + 1'b1;
        if (step_r == DIV_LAST) state_nxt = ST_MEAN;
      end
      ST_MEAN: begin
        cmd.op    = OP_MEAN;
        state_nxt = ST_DELTA2;
      end
      ST_DELTA2: begin
        cmd.op    = OP_DELTA2;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.op   = OP_MUL_STEP;
        step_nxt = step_r + 1'b1;
        if (step_r == MUL_LAST) state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.op    = OP_ACC;
        state_nxt = sts.count_gt1 ? ST_DIV_VAR : ST_STD;
      end
      ST_DIV_VAR: begin
        cmd.op   = OP_DIV_STEP;
        step_nxt = step_r + 1'b1;
        if (step_r == DIV_LAST) state_nxt = ST_SQRT_INIT;
      end
      ST_SQRT_INIT: begin
        cmd.op    = OP_SQRT_INIT;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.op   = OP_SQRT_STEP;
        step_nxt = step_r + 1'b1;
        if (step_r == SQRT_LAST) state_nxt = ST_STD;
      end
      ST_STD: begin
        cmd.op    = OP_STD;
        state_nxt = ST_DIV_FACT;
      end
      ST_DIV_FACT: begin
        cmd.op   = OP_DIV_STEP;
        step_nxt = step_r + 1'b1;
        if (step_r == DIV_LAST) state_nxt = ST_SCORE;
      end
      ST_SCORE: begin
        cmd.op    = OP_SCORE;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!sts.out_busy) begin
          cmd.op    = OP_OUT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

[rtl/rsqt_dp.sv]
// Datapath: Welford state, shared divider, multiplier, square root and output register.
`timescale 1ns / 1ps
module rsqt_dp
  import rsqt_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  rsqt_cmd_t                  cmd,
  output rsqt_sts_t                  sts,
  input  logic [SAMPLE_BITS-1:0]     sample,
  input  logic                       cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [CFG_DATA_BITS-1:0]   cfg_data,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [OUT_DATA_BITS-1:0]   out_tdata
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [STD_BITS-1:0]   STD_MAX = '1;
  localparam logic [Q16_BITS-1:0]   Q16_ONE = 17'd65536;

  // Welford state and configuration
  logic [COUNT_BITS-1:0]        cnt_r;
  logic signed [MEAN_BITS-1:0]  mean_r, x_r;
  logic [SUM_BITS-1:0]          sq_r;
  logic [MIN_BITS-1:0]          min_r;
  logic [LIM_BITS-1:0]          lim_r;
  // working registers
  logic signed [MEAN_BITS:0]    delta_r;
  logic [MEAN_BITS-1:0]         dmag_r, mb_r;
  logic                         add_en_r;
  logic [SUM_BITS-1:0]          num_r;
  logic [COUNT_BITS:0]          rem_r;
  logic [COUNT_BITS-1:0]        den_r;
  logic [2*MEAN_BITS-1:0]       prod_r;
  logic [SUM_BITS-1:0]          sqx_r, res_r, bit_r;
  logic [STD_BITS-1:0]          std_r;
  logic [Q16_BITS-1:0]          score_r;
  logic                         out_valid_r, out_valid_nxt;
  logic [OUT_DATA_BITS-1:0]     out_data_r;

  logic [COUNT_BITS:0]          rem_sh, rem_sub;
  logic                         qbit;
  logic signed [MEAN_BITS+1:0]  quo_s, mean_sum;
  logic signed [MEAN_BITS:0]    d2;
  logic [MEAN_BITS:0]           mul_hi;
  logic [SUM_BITS-1:0]          add_v, sq_new, sq_try;
  logic [SUM_BITS:0]            sq_sum;
  logic [COUNT_BITS-1:0]        cnt_inc;
  logic [MIN_BITS+1:0]          denom;
  logic [Q16_BITS-1:0]          factor, bucket, wbucket, weight;
  logic [2*Q16_BITS-1:0]        sc_prod, wt_prod;
  logic [STD_BITS-1:0]          std_new;
  logic [Q16_BITS+3:0]          score10;
  logic                         good, suitable, few;
  logic signed [MEAN_BITS-1:0]  mean_sh;

  assign cnt_inc = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
  assign denom   = {2'b00, min_r} + {1'b0, min_r, 1'b0};

  // one restoring divide step, quotient shifts into num_r
  assign rem_sh  = {rem_r[COUNT_BITS-1:0], num_r[SUM_BITS-1]};
  assign qbit    = (rem_sh >= {1'b0, den_r});
  assign rem_sub = qbit ? rem_sh - {1'b0, den_r} : rem_sh;

  assign quo_s    = delta_r[MEAN_BITS] ? -$signed({1'b0, num_r[MEAN_BITS:0]})
                                       :  $signed({1'b0, num_r[MEAN_BITS:0]});
  assign mean_sum = {{2{mean_r[MEAN_BITS-1]}}, mean_r} + quo_s;
  // sample minus the current mean: delta before the mean update, delta2 after
  assign d2       = {x_r[MEAN_BITS-1], x_r} - {mean_r[MEAN_BITS-1], mean_r};

  assign mul_hi   = {1'b0, prod_r[2*MEAN_BITS-1:MEAN_BITS]} +
                    (mb_r[0] ? {1'b0, dmag_r} : '0);

  assign add_v  = add_en_r ? prod_r[2*MEAN_BITS-1:2*MEAN_EXTRA] : '0;
  assign sq_sum = {1'b0, sq_r} + {1'b0, add_v};
  assign sq_new = sq_sum[SUM_BITS] ? '1 : sq_sum[SUM_BITS-1:0];
  assign sq_try = res_r + bit_r;

  assign std_new = !sts.count_gt1 ? '0 :
                   (res_r[SUM_BITS-1:STD_BITS] != '0) ? STD_MAX : res_r[STD_BITS-1:0];

  always_comb begin
    if (std_r < STD_BITS'(5 << FRAC_BITS))       bucket = Q16_ONE;
    else if (std_r < STD_BITS'(15 << FRAC_BITS)) bucket = 17'd52429;
    else if (std_r < STD_BITS'(25 << FRAC_BITS)) bucket = 17'd39322;
    else if (std_r < STD_BITS'(35 << FRAC_BITS)) bucket = 17'd26214;
    else                                          bucket = 17'd13107;
    if (std_r < STD_BITS'(10 << FRAC_BITS))      wbucket = Q16_ONE;
    else if (std_r < STD_BITS'(20 << FRAC_BITS)) wbucket = 17'd45875;
    else if (std_r < STD_BITS'(30 << FRAC_BITS)) wbucket = 17'd26214;
    else                                          wbucket = 17'd13107;
  end

  assign factor  = ({8'd0, cnt_r} >= {14'd0, denom}) ? Q16_ONE : {1'b0, num_r[15:0]};
  assign sc_prod = bucket * factor;
  assign wt_prod = wbucket * score_r;
  assign few     = {8'd0, cnt_r} < {16'd0, min_r};
  assign weight  = few ? 17'd32768 : wt_prod[Q16_BITS+15:16];
  assign suitable = few | (std_r < lim_r);
  assign score10 = {score_r, 3'b000} + {2'b00, score_r, 1'b0};
  assign good    = score10 > 21'(7 * 65536);
  assign mean_sh = mean_r >>> MEAN_EXTRA;

  assign out_valid_nxt = (cmd.op == OP_OUT) || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      mean_r <= '0;
      sq_r   <= '0;
      min_r  <= MIN_SAMPLES_RST;
      lim_r  <= STD_LIMIT_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_MIN_SAMPLES: min_r <= cfg_data[MIN_BITS-1:0];
          CFG_STD_LIMIT:   lim_r <= cfg_data[LIM_BITS-1:0];
          default: ;
        endcase
      end
      out_valid_r <= out_valid_nxt;
      unique case (cmd.op)
        OP_LOAD: cnt_r  <= cnt_inc;
        OP_MEAN: mean_r <= mean_sum[MEAN_BITS-1:0];
        OP_ACC:  sq_r   <= sq_new;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: x_r <= {sample, {MEAN_EXTRA{1'b0}}};
      OP_DELTA: begin
        delta_r <= d2;
        num_r   <= {{(SUM_BITS-MEAN_BITS){1'b0}},
                    d2[MEAN_BITS] ? MEAN_BITS'(-d2) : d2[MEAN_BITS-1:0]};
        den_r   <= cnt_r;
        rem_r   <= '0;
      end
      OP_DIV_STEP: begin
        rem_r <= rem_sub;
        num_r <= {num_r[SUM_BITS-2:0], qbit};
      end
      OP_DELTA2: begin
        dmag_r   <= delta_r[MEAN_BITS] ? MEAN_BITS'(-delta_r) : delta_r[MEAN_BITS-1:0];
        mb_r     <= d2[MEAN_BITS] ? MEAN_BITS'(-d2) : d2[MEAN_BITS-1:0];
        add_en_r <= (delta_r[MEAN_BITS] == d2[MEAN_BITS]) || (delta_r == '0) || (d2 == '0);
        prod_r   <= '0;
      end
      OP_MUL_STEP: begin
        prod_r <= {mul_hi, prod_r[MEAN_BITS-1:1]};
        mb_r   <= mb_r >> 1;
      end
      OP_ACC: begin
        num_r <= sq_new;
        den_r <= cnt_r - 1'b1;
        rem_r <= '0;
      end
      OP_SQRT_INIT: begin
        sqx_r <= num_r;
        res_r <= '0;
        bit_r <= {2'b01, {(SUM_BITS-2){1'b0}}};
      end
      OP_SQRT_STEP: begin
        if (sqx_r >= sq_try) begin
          sqx_r <= sqx_r - sq_try;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      OP_STD: begin
        std_r <= std_new;
        num_r <= {{(SUM_BITS-COUNT_BITS-16){1'b0}}, cnt_r, 16'd0};
        den_r <= COUNT_BITS'(denom);
        rem_r <= '0;
      end
      OP_SCORE: score_r <= sc_prod[Q16_BITS+15:16];
      OP_OUT: out_data_r <= {5'd0, suitable, weight, good, score_r, std_r,
                             mean_sh[SAMPLE_BITS-1:0], cnt_r};
      default: ;
    endcase
  end

  assign sts.count_gt1 = cnt_r > COUNT_BITS'(1);
  assign sts.out_busy  = out_valid_r && !out_tready;
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;

endmodule
